// File: rtl/dmvir_pkg.sv
// Package holding the shared types, constants and helper function of the index renderer.
`default_nettype none
package dmvir_pkg;

	localparam int CELL_W = 6;
	localparam int ROW_W = 9;
	localparam int IDX_W = 5;

	localparam int FRAME_CELLS_DEF = 44;
	localparam int FRAME_ROWS_DEF = 288;
	localparam int SIDE_BORDER_CELLS_DEF = 6;
	localparam int TOP_BORDER_ROWS_DEF = 48;
	localparam int SCREEN_CELLS = 32;
	localparam int SCREEN_ROWS = 192;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] CMD_PORT_FE = 2'd0;
	localparam logic [1:0] CMD_PORT_FF = 2'd1;
	localparam logic [1:0] CMD_CELL = 2'd2;

	localparam logic [3:0] IDX_TRANSPARENT = 4'd8;
	localparam logic [IDX_W-1:0] IDX_GREY = 5'd16;
	localparam logic [3:0] PEN_RESET = 4'd15;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] port_value;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       flash_phase;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] pix_0;
		logic [IDX_W-1:0] pix_1;
		logic [IDX_W-1:0] pix_2;
		logic [IDX_W-1:0] pix_3;
		logic [IDX_W-1:0] pix_4;
		logic [IDX_W-1:0] pix_5;
		logic [IDX_W-1:0] pix_6;
		logic [IDX_W-1:0] pix_7;
		logic             row_done;
		logic             frame_done;
	} result_t;

	// One classified cell, as handed from the front end to the renderer.
	typedef struct packed {
		logic       in_screen;
		logic       wide;
		logic [3:0] border_index;
		logic [3:0] wide_pen;
		logic [3:0] wide_paper;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       flash_phase;
		logic       row_done;
		logic       frame_done;
	} job_t;

	// Index 8 is never shown; it becomes index 0.
	function automatic logic [3:0] no_transp(input logic [3:0] c);
		return (c == IDX_TRANSPARENT) ? 4'd0 : c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/dmvir_front.sv
// Front end: takes port writes and cells, keeps mode and raster position, classifies cells.
`default_nettype none
module dmvir_front
	import dmvir_pkg::*;
#(
	parameter int FRAME_CELLS = FRAME_CELLS_DEF,
	parameter int FRAME_ROWS = FRAME_ROWS_DEF,
	parameter int SIDE_BORDER_CELLS = SIDE_BORDER_CELLS_DEF,
	parameter int TOP_BORDER_ROWS = TOP_BORDER_ROWS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire item_t item,
	output logic       job_push,
	output job_t       job
);

	localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(FRAME_CELLS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_ROWS - 1);
	localparam logic [CELL_W-1:0] SCREEN_CELL_FIRST = CELL_W'(SIDE_BORDER_CELLS);
	localparam logic [CELL_W-1:0] SCREEN_CELL_END = CELL_W'(SIDE_BORDER_CELLS + SCREEN_CELLS);
	localparam logic [ROW_W-1:0] SCREEN_ROW_FIRST = ROW_W'(TOP_BORDER_ROWS);
	localparam logic [ROW_W-1:0] SCREEN_ROW_END = ROW_W'(TOP_BORDER_ROWS + SCREEN_ROWS);

	logic              wide_mode_q;
	logic [2:0]        plain_border_q;
	logic [3:0]        border_index_q;
	logic [3:0]        wide_pen_q;
	logic [3:0]        wide_paper_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] cell_q;

	logic       last_cell;
	logic       last_row;
	logic [3:0] ff_pen;
	logic [3:0] ff_paper;
	logic       ff_wide;

	assign last_cell = (cell_q == LAST_CELL);
	assign last_row = (row_q == LAST_ROW);
	assign ff_wide = item.port_value[2];
	assign ff_pen = no_transp({1'b1, item.port_value[5:3]});
	assign ff_paper = no_transp({1'b1, ~item.port_value[5:3]});

	assign job_push = fire && (item.cmd == CMD_CELL);

	always_comb begin
		job.in_screen = (row_q >= SCREEN_ROW_FIRST) && (row_q < SCREEN_ROW_END) &&
			(cell_q >= SCREEN_CELL_FIRST) && (cell_q < SCREEN_CELL_END);
		job.wide = wide_mode_q;
		job.border_index = border_index_q;
		job.wide_pen = wide_pen_q;
		job.wide_paper = wide_paper_q;
		job.first_byte = item.first_byte;
		job.second_byte = item.second_byte;
		job.flash_phase = item.flash_phase;
		job.row_done = last_cell;
		job.frame_done = last_cell && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b0;
			plain_border_q <= 3'd0;
			border_index_q <= 4'd0;
			wide_pen_q <= PEN_RESET;
			wide_paper_q <= 4'd0;
			row_q <= '0;
			cell_q <= '0;
		end else if (fire) begin
			unique case (item.cmd)
				CMD_PORT_FE: begin
					plain_border_q <= item.port_value[2:0];
					if (!wide_mode_q) begin
						border_index_q <= {1'b0, item.port_value[2:0]};
					end
				end
				CMD_PORT_FF: begin
					wide_mode_q <= ff_wide;
					wide_pen_q <= ff_pen;
					wide_paper_q <= ff_paper;
					border_index_q <= ff_wide ? ff_paper : {1'b0, plain_border_q};
				end
				CMD_CELL: begin
					if (last_cell) begin
						cell_q <= '0;
						row_q <= last_row ? '0 : row_q + 1'b1;
					end else begin
						cell_q <= cell_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/dmvir_queue.sv
// Short first-in first-out queue of classified cells between front end and renderer.
`default_nettype none
module dmvir_queue
	import dmvir_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output job_t      rd_data,
	output logic      nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/dmvir_back.sv
// Renderer: turns a classified cell into eight palette indices held in the result register.
`default_nettype none
module dmvir_back
	import dmvir_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_ready,
	input  wire job_t job,
	output logic      job_take,
	output logic      empty,
	input  wire logic pop,
	output result_t   result
);

	logic    out_valid_q;
	result_t out_q;
	result_t rendered;

	function automatic logic [IDX_W-1:0] wide_pair(input logic [1:0] bits,
		input logic [3:0] pen, input logic [3:0] paper);
		logic [IDX_W-1:0] r;
		unique case (bits)
			2'b00: r = {1'b0, paper};
			2'b11: r = {1'b0, pen};
			default: r = IDX_GREY;
		endcase
		return r;
	endfunction

	always_comb begin
		logic [IDX_W-1:0] px [8];
		logic [3:0]       pen;
		logic [3:0]       paper;
		logic [7:0]       bits;
		logic [15:0]      wide_bits;
		pen = no_transp({job.second_byte[6], job.second_byte[2:0]});
		paper = no_transp(job.second_byte[6:3]);
		bits = job.first_byte ^ {8{job.second_byte[7] & job.flash_phase}};
		// In 64-column mode the two bytes form one run of eight bit pairs, left byte first.
		wide_bits = {job.first_byte, job.second_byte};
		for (int k = 0; k < 8; k++) begin
			priority if (!job.in_screen) begin
				px[k] = {1'b0, job.border_index};
			end else if (job.wide) begin
				px[k] = wide_pair(wide_bits[15-2*k -: 2], job.wide_pen, job.wide_paper);
			end else begin
				px[k] = bits[7-k] ? {1'b0, pen} : {1'b0, paper};
			end
		end
		rendered.pix_0 = px[0];
		rendered.pix_1 = px[1];
		rendered.pix_2 = px[2];
		rendered.pix_3 = px[3];
		rendered.pix_4 = px[4];
		rendered.pix_5 = px[5];
		rendered.pix_6 = px[6];
		rendered.pix_7 = px[7];
		rendered.row_done = job.row_done;
		rendered.frame_done = job.frame_done;
	end

	assign job_take = job_ready && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			out_q <= rendered;
		end
	end

endmodule
`default_nettype wire

// File: rtl/dual_mode_video_index_render.sv
// Top level of the two-mode palette-index raster generator.
//
//   channel   direction   handshake              payload
//   -------   ---------   --------------------   ----------------------------------
//   item      in          push / full            port write or one raster cell
//   result    out         empty / pop            eight palette indices, row/frame end
//
// One item may be pushed on every clock edge while full is low. A cell is held in the
// cell queue and then in the result register before it appears on the result port;
// port writes update the mode registers at once and give no result.
// full follows the small cell queue between the front end and the renderer, so the
// input stalls only once the queue and the result register are both occupied.
// Reset puts 32-column mode, border index 0, pen 15, paper 0 and the raster at the
// first cell of the frame, and leaves the cell queue and the result register empty.
`default_nettype none
module dual_mode_video_index_render
	import dmvir_pkg::*;
#(
	parameter int FRAME_CELLS = FRAME_CELLS_DEF,
	parameter int FRAME_ROWS = FRAME_ROWS_DEF,
	parameter int SIDE_BORDER_CELLS = SIDE_BORDER_CELLS_DEF,
	parameter int TOP_BORDER_ROWS = TOP_BORDER_ROWS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);

	logic fire;
	logic job_push;
	job_t job_in;
	job_t job_out;
	logic job_ready;
	logic job_take;

	// An item is taken whenever the cell queue has room; port writes never occupy it,
	// but gating them as well keeps the acceptance rule a single term.
	assign fire = push && !full;

	dmvir_front #(
		.FRAME_CELLS(FRAME_CELLS),
		.FRAME_ROWS(FRAME_ROWS),
		.SIDE_BORDER_CELLS(SIDE_BORDER_CELLS),
		.TOP_BORDER_ROWS(TOP_BORDER_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item),
		.job_push(job_push),
		.job(job_in)
	);

	dmvir_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_data(job_in),
		.full(full),
		.rd_en(job_take),
		.rd_data(job_out),
		.nonempty(job_ready)
	);

	// The renderer holds the finished cell in its result register, so it can take
	// the next queued cell in the same cycle as the current one is popped.
	dmvir_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_ready(job_ready),
		.job(job_out),
		.job_take(job_take),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
`default_nettype wire

// File: tb/tb_dual_mode_video_index_render.sv
// Self-checking testbench for the two-mode palette-index raster generator.
`timescale 1ns / 100ps
module tb_dual_mode_video_index_render;
	import dmvir_pkg::*;

	// The fourth command code has no meaning. The block must drop it without a trace.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// The watchdog allows for the long receiver hold-off and for the sender's gaps.
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS = 850;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	item_t   item = '0;
	logic    pop = 1'b0;
	logic    full;
	logic    empty;
	result_t result;

	// Our own copy of the block's state. It is advanced by the sending process
	// at the edge where each item is accepted.
	logic        mode_wide = 1'b0;
	logic [2:0]  border_plain = 3'd0;
	logic [3:0]  border_shown = 4'd0;
	logic [3:0]  wide_ink = PEN_RESET;
	logic [3:0]  wide_back = 4'd0;
	int unsigned ras_row = 0;
	int unsigned ras_cell = 0;

	// Rendered cells that are still to come out of the block, oldest first.
	result_t due_renders[$];

	// Pacing of both sides. The tests switch these to vary the traffic.
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit hold_request = 1'b0;
	int burst_left = 0;
	int hold_left = 0;
	int rx_phase = 0;
	int quiet = 0;

	// Counters for the verdict and the closing summary.
	int mismatches = 0;
	int cells_sent = 0;
	int writes_sent = 0;
	int frames_seen = 0;
	int renders_checked = 0;
	int input_stalls = 0;

	dual_mode_video_index_render dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Palette index 8 is never shown. The block turns it into index 0.
	function automatic logic [3:0] drop_index_eight(input logic [3:0] c);
		return (c == IDX_TRANSPARENT) ? 4'd0 : c;
	endfunction

	// In 64-column mode each pair of pixel bits picks paper, pen or the grey index.
	function automatic logic [IDX_W-1:0] wide_index(input logic [1:0] pair);
		case (pair)
		2'b00: return {1'b0, wide_back};
		2'b11: return {1'b0, wide_ink};
		default: return IDX_GREY;
		endcase
	endfunction

	// Advances the state copy by one accepted transaction. A raster cell also
	// queues the cell that the block should render for it.
	task automatic predict_item(input item_t it);
		logic [3:0]       ink;
		logic [3:0]       back;
		logic [7:0]       bits;
		logic             on_screen;
		logic [IDX_W-1:0] px [8];
		result_t          r;
		case (it.cmd)
		CMD_PORT_FE: begin
			// In 64-column mode the colour is stored, but the shown border keeps the paper.
			border_plain = it.port_value[2:0];
			if (!mode_wide)
				border_shown = {1'b0, border_plain};
			writes_sent++;
		end
		CMD_PORT_FF: begin
			// The pen comes from the bright half of the palette, and the paper is its complement.
			ink = {1'b1, it.port_value[5:3]};
			back = ink ^ 4'd7;
			mode_wide = it.port_value[2];
			wide_ink = drop_index_eight(ink);
			wide_back = drop_index_eight(back);
			border_shown = mode_wide ? wide_back : {1'b0, border_plain};
			writes_sent++;
		end
		CMD_CELL: begin
			on_screen = ras_row >= TOP_BORDER_ROWS_DEF &&
				ras_row < TOP_BORDER_ROWS_DEF + SCREEN_ROWS &&
				ras_cell >= SIDE_BORDER_CELLS_DEF &&
				ras_cell < SIDE_BORDER_CELLS_DEF + SCREEN_CELLS;
			if (!on_screen) begin
				for (int k = 0; k < 8; k++)
					px[k] = {1'b0, border_shown};
			end else if (mode_wide) begin
				// Flash has no effect in this mode. Both bytes are pixel data.
				for (int k = 0; k < 4; k++) begin
					px[k] = wide_index(it.first_byte[7-2*k -: 2]);
					px[k+4] = wide_index(it.second_byte[7-2*k -: 2]);
				end
			end else begin
				// The bright bit lifts the ink and the paper into the upper half of the palette.
				ink = drop_index_eight({it.second_byte[6], it.second_byte[2:0]});
				back = drop_index_eight(it.second_byte[6:3]);
				bits = (it.second_byte[7] && it.flash_phase) ? ~it.first_byte : it.first_byte;
				for (int k = 0; k < 8; k++)
					px[k] = bits[7-k] ? {1'b0, ink} : {1'b0, back};
			end
			r.pix_0 = px[0];
			r.pix_1 = px[1];
			r.pix_2 = px[2];
			r.pix_3 = px[3];
			r.pix_4 = px[4];
			r.pix_5 = px[5];
			r.pix_6 = px[6];
			r.pix_7 = px[7];
			r.row_done = (ras_cell + 1 >= FRAME_CELLS_DEF);
			r.frame_done = 1'b0;
			if (r.row_done) begin
				ras_cell = 0;
				if (ras_row + 1 >= FRAME_ROWS_DEF) begin
					r.frame_done = 1'b1;
					ras_row = 0;
					frames_seen++;
				end else begin
					ras_row++;
				end
			end else begin
				ras_cell++;
			end
			due_renders.push_back(r);
			cells_sent++;
		end
		default: ;
		endcase
	endtask

	// Offers one item and returns once the block has taken it. The sender works
	// in bursts. Between bursts push is lowered when gaps are enabled. push is
	// never lowered and raised again at the same edge.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] pv,
			input logic [7:0] b0, input logic [7:0] b1, input logic fl);
		item_t it;
		it.cmd = cmd;
		it.port_value = pv;
		it.first_byte = b0;
		it.second_byte = b1;
		it.flash_phase = fl;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		predict_item(it);
	endtask

	// Mostly raster cells, with port writes and the odd unused command mixed in.
	task automatic send_random_item();
		int         pick;
		logic [1:0] cmd;
		pick = $urandom_range(0, 99);
		if (pick < 84)
			cmd = CMD_CELL;
		else if (pick < 91)
			cmd = CMD_PORT_FE;
		else if (pick < 98)
			cmd = CMD_PORT_FF;
		else
			cmd = CMD_UNUSED;
		send_item(cmd, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 1));
	endtask

	// Lowers push, then waits until every cell has come out.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (due_renders.size() != 0)
			@(posedge clk);
	endtask

	// Row 0 is all border. This test checks how the border colour follows both
	// ports and both modes, starting from the reset colour.
	task automatic test_border_colours();
		send_item(CMD_CELL, 8'hFF, 8'hFF, 8'h00, 1'b1);
		send_item(CMD_PORT_FE, 8'h07, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h00, 8'hFF, 1'b0);
		send_item(CMD_PORT_FE, 8'hF8, 8'hFF, 8'hFF, 1'b1);
		send_item(CMD_CELL, 8'h00, 8'h55, 8'hAA, 1'b0);
		send_item(CMD_PORT_FF, 8'h2C, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h00, 8'h00, 1'b0);
		send_item(CMD_PORT_FE, 8'h03, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'hFF, 8'hFF, 1'b1);
		send_item(CMD_PORT_FF, 8'hFB, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h00, 8'h00, 1'b0);
		send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_item(CMD_CELL, 8'hFF, 8'h00, 8'h00, 1'b0);
		wait_drained();
	endtask

	// Random traffic until the next cell is the top-left cell of the screen window.
	// The border rows and the row ends on the way are checked as they pass.
	task automatic test_walk_to_screen();
		while (!(ras_row == TOP_BORDER_ROWS_DEF && ras_cell == SIDE_BORDER_CELLS_DEF))
			send_random_item();
		wait_drained();
	endtask

	// Cells inside the screen window, in both modes. This covers flash in either
	// phase, bright, index 8 turned into 0, the grey pairs, and flash being ignored
	// in 64-column mode.
	task automatic test_screen_cells();
		send_item(CMD_PORT_FF, 8'h00, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_item(CMD_CELL, 8'hF0, 8'hF0, 8'hC7, 1'b1);
		send_item(CMD_CELL, 8'h00, 8'hA5, 8'h40, 1'b1);
		send_item(CMD_CELL, 8'h00, 8'h3C, 8'h38, 1'b1);
		send_item(CMD_CELL, 8'h00, 8'h81, 8'h87, 1'b0);
		send_item(CMD_PORT_FF, 8'h04, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h1B, 8'hE4, 1'b1);
		send_item(CMD_CELL, 8'h00, 8'hFF, 8'h00, 1'b0);
		send_item(CMD_PORT_FE, 8'h05, 8'h00, 8'h00, 1'b0);
		send_item(CMD_PORT_FF, 8'h3C, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h55, 8'hAA, 1'b1);
		send_item(CMD_PORT_FF, 8'h00, 8'h00, 8'h00, 1'b0);
		send_item(CMD_CELL, 8'h00, 8'h0F, 8'h79, 1'b1);
		wait_drained();
	endtask

	// The random run goes in segments. Sender gaps and receiver stalls are switched
	// per segment, so that some stretches run at full rate on both sides.
	task automatic test_random_traffic();
		for (int seg = 0; seg < 10; seg++) begin
			gaps_on = (seg % 3) != 0;
			stalls_on = (seg % 4) != 1;
			repeat (RANDOM_ITEMS / 10)
				send_random_item();
		end
		wait_drained();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// The receiver stops popping for a long stretch while the sender keeps pushing
	// cells back to back. The block must fill up, raise full and lose nothing.
	task automatic test_input_backpressure();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (60)
			send_item(CMD_CELL, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 1));
		wait_drained();
		gaps_on = 1'b1;
	endtask

	// Runs the raster through the bottom of the screen and the bottom border to the
	// end of the frame, then a few cells into the next frame.
	task automatic test_frame_wrap();
		int start_frames;
		start_frames = frames_seen;
		while (frames_seen == start_frames)
			send_random_item();
		repeat (12)
			send_item(CMD_CELL, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 1));
		wait_drained();
	endtask

	// Receiver. It pops on a repeating pattern with random extra stalls. When the
	// backpressure test asks for a hold-off, it counts that hold-off itself.
	always @(posedge clk) begin
		rx_phase = (rx_phase + 1) % 13;
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
			pop <= 1'b0;
		end else if (stalls_on) begin
			pop <= !(rx_phase < 3 || rx_phase == 7 || $urandom_range(0, 9) == 0);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic compare_field(input string field, input logic [IDX_W-1:0] want,
			input logic [IDX_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Checks each popped result against the oldest cell still due. Single-bit
	// flags are widened to the index width for the comparison.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && pop && !empty) begin
			if (due_renders.size() == 0) begin
				$display("%0t: result with no cell due, expected none, got %p", $time, result);
				mismatches++;
			end else begin
				want = due_renders.pop_front();
				compare_field("pix_0", want.pix_0, result.pix_0);
				compare_field("pix_1", want.pix_1, result.pix_1);
				compare_field("pix_2", want.pix_2, result.pix_2);
				compare_field("pix_3", want.pix_3, result.pix_3);
				compare_field("pix_4", want.pix_4, result.pix_4);
				compare_field("pix_5", want.pix_5, result.pix_5);
				compare_field("pix_6", want.pix_6, result.pix_6);
				compare_field("pix_7", want.pix_7, result.pix_7);
				compare_field("row_done", {4'd0, want.row_done}, {4'd0, result.row_done});
				compare_field("frame_done", {4'd0, want.frame_done}, {4'd0, result.frame_done});
				renders_checked++;
			end
		end
	end

	// Watchdog. The run is ended if no transaction happens on either side for too long.
	// It also counts the cycles in which the input was held off.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
		if (push && full)
			input_stalls++;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_border_colours();
		test_walk_to_screen();
		test_screen_cells();
		test_random_traffic();
		test_input_backpressure();
		test_frame_wrap();

		// Leave room for any late or spurious result to show up.
		repeat (4) @(posedge clk);

		$display("Covered %0d raster cells and %0d port writes across %0d frame wrap(s).",
			cells_sent, writes_sent, frames_seen);
		$display("Checked %0d rendered cells; the input was held off for %0d cycles.",
			renders_checked, input_stalls);
		if (mismatches == 0 && due_renders.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d cells never rendered", mismatches,
				due_renders.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
